/* src/e2pd_pkg.sv */
`timescale 1ns / 1ps

package e2pd_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = $clog2(PAGE_BYTES);
    localparam int POS_W      = ADDR_W + 1;
    localparam int SUM_W      = POS_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    // record kinds from the two low header bits
    localparam logic [1:0] KIND_RUN_OR_LIT = 2'b00;
    localparam logic [1:0] KIND_SHORT      = 2'b01;
    localparam logic [1:0] KIND_COPY       = 2'b10;
    localparam logic [1:0] KIND_LONG       = 2'b11;

    // one decoded transaction: rep copies of byte_val, then a back copy
    typedef struct packed {
        logic [7:0]        byte_val;
        logic [7:0]        rep;
        logic [5:0]        copy_len;
        logic [ADDR_W-1:0] offs;
        logic              final_step;
        logic              err;
    } cmd_t;

    typedef struct packed {
        logic [31:0]      data;
        logic [2:0]       count;
        logic             last;
        logic             status;
        logic [POS_W-1:0] total;
    } res_t;

endpackage

/* src/e2pd_front.sv */
`timescale 1ns / 1ps

module e2pd_front
    import e2pd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] src_byte,
    input  logic       src_last,
    output logic       push,
    output cmd_t       cmd
);

    typedef enum logic [5:0] {
        PH_HEADER      = 6'b000001,
        PH_HEADER_MORE = 6'b000010,
        PH_RUN_COUNT   = 6'b000100,
        PH_RUN_VALUE   = 6'b001000,
        PH_LITERAL     = 6'b010000,
        PH_DRAIN       = 6'b100000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  wp_reg, wp_next;
    logic [23:0]       hdr_reg, hdr_next;
    logic [1:0]        hcnt_reg, hcnt_next;
    logic [5:0]        lit_reg, lit_next;
    logic [5:0]        plen_reg, plen_next;
    logic [ADDR_W-1:0] pdist_reg, pdist_next;

    logic [23:0]       w;
    logic              hdr_done;
    logic [3:0]        f_lit;
    logic [5:0]        f_len;
    logic [ADDR_W-1:0] f_dist;
    logic [SUM_W-1:0]  span;
    logic [SUM_W-1:0]  reach;
    logic              fin;
    logic              bad;

    // header word with the incoming byte merged in
    always_comb
    begin
        if (hcnt_reg == 2'd1)
        begin
            w = {hdr_reg[23:16], src_byte, hdr_reg[7:0]};
        end
        else
        begin
            w = {src_byte, hdr_reg[15:0]};
        end
        hdr_done = (hdr_reg[1:0] == KIND_LONG) ? (hcnt_reg == 2'd2) : 1'b1;
    end

    // field split of the three back-reference forms
    always_comb
    begin
        unique case (w[1:0])
            KIND_SHORT:
            begin
                f_lit  = {2'b00, w[3:2]};
                f_len  = {3'b000, w[6:4]} + 6'd3;
                f_dist = {3'b000, w[15:7]};
            end
            KIND_COPY:
            begin
                f_lit  = 4'd0;
                f_len  = {4'b0000, w[3:2]} + 6'd3;
                f_dist = w[15:4];
            end
            KIND_LONG:
            begin
                f_lit  = w[5:2];
                f_len  = w[11:6];
                f_dist = w[23:12];
            end
            default:
            begin
                f_lit  = 4'd0;
                f_len  = 6'd0;
                f_dist = '0;
            end
        endcase
        span  = {1'b0, wp_reg} + SUM_W'(f_lit) + SUM_W'(f_len);
        reach = {1'b0, wp_reg} + SUM_W'(f_lit);
    end

    // record decoding and end-of-page handling
    always_comb
    begin
        phase_next = phase_reg;
        wp_next    = wp_reg;
        hdr_next   = hdr_reg;
        hcnt_next  = hcnt_reg;
        lit_next   = lit_reg;
        plen_next  = plen_reg;
        pdist_next = pdist_reg;
        push       = 1'b0;
        cmd        = '0;
        fin        = 1'b0;
        bad        = 1'b0;
        if (accept)
        begin
            cmd.byte_val = src_byte;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (src_byte[1:0] == KIND_RUN_OR_LIT)
                    begin
                        if (src_byte == 8'd0)
                        begin
                            if (src_last)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_RUN_COUNT;
                            end
                        end
                        else if ({1'b0, wp_reg} + SUM_W'(src_byte[7:2]) > SUM_W'(PAGE_BYTES))
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            lit_next   = src_byte[7:2];
                            plen_next  = '0;
                            pdist_next = '0;
                            phase_next = PH_LITERAL;
                        end
                    end
                    else
                    begin
                        hdr_next   = {16'd0, src_byte};
                        hcnt_next  = 2'd1;
                        phase_next = PH_HEADER_MORE;
                    end
                end
                PH_HEADER_MORE:
                begin
                    hdr_next  = w;
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hdr_done)
                    begin
                        hcnt_next = 2'd0;
                        if (span > SUM_W'(PAGE_BYTES))
                        begin
                            bad = 1'b1;
                        end
                        else if (f_len != 6'd0 &&
                                 (f_dist == '0 || SUM_W'(f_dist) > reach))
                        begin
                            bad = 1'b1;
                        end
                        else if (f_lit != 4'd0)
                        begin
                            lit_next   = {2'b00, f_lit};
                            plen_next  = f_len;
                            pdist_next = f_dist;
                            phase_next = PH_LITERAL;
                        end
                        else
                        begin
                            cmd.copy_len = f_len;
                            cmd.offs     = f_dist;
                            wp_next      = wp_reg + POS_W'(f_len);
                            phase_next   = PH_HEADER;
                        end
                    end
                end
                PH_RUN_COUNT:
                begin
                    if (src_byte == 8'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        hdr_next   = {16'd0, src_byte};
                        phase_next = PH_RUN_VALUE;
                    end
                end
                PH_RUN_VALUE:
                begin
                    if ({1'b0, wp_reg} + SUM_W'(hdr_reg[7:0]) > SUM_W'(PAGE_BYTES))
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        cmd.rep    = hdr_reg[7:0];
                        wp_next    = wp_reg + POS_W'(hdr_reg[7:0]);
                        hdr_next   = '0;
                        phase_next = PH_HEADER;
                    end
                end
                PH_LITERAL:
                begin
                    cmd.rep  = 8'd1;
                    lit_next = lit_reg - 6'd1;
                    if (lit_reg == 6'd1)
                    begin
                        cmd.copy_len = plen_reg;
                        cmd.offs     = pdist_reg;
                        wp_next      = wp_reg + POS_W'(plen_reg) + POS_W'(1);
                        plen_next    = '0;
                        pdist_next   = '0;
                        phase_next   = PH_HEADER;
                    end
                    else
                    begin
                        wp_next = wp_reg + POS_W'(1);
                    end
                end
                PH_DRAIN:
                begin
                    if (src_last)
                    begin
                        wp_next    = '0;
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            if (phase_reg != PH_DRAIN)
            begin
                // last byte with the record incomplete is truncation
                if (!fin && !bad && src_last)
                begin
                    if (phase_next == PH_HEADER)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                push = (cmd.rep != 8'd0) || (cmd.copy_len != 6'd0) || fin || bad;
                if (fin || bad)
                begin
                    cmd.final_step = 1'b1;
                    cmd.err        = bad;
                    hdr_next   = '0;
                    hcnt_next  = '0;
                    lit_next   = '0;
                    plen_next  = '0;
                    pdist_next = '0;
                    if (src_last)
                    begin
                        wp_next    = '0;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_DRAIN;
                    end
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            wp_reg    <= '0;
            hdr_reg   <= '0;
            hcnt_reg  <= '0;
            lit_reg   <= '0;
            plen_reg  <= '0;
            pdist_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            hdr_reg   <= hdr_next;
            hcnt_reg  <= hcnt_next;
            lit_reg   <= lit_next;
            plen_reg  <= plen_next;
            pdist_reg <= pdist_next;
        end
    end

endmodule

/* src/e2pd_queue.sv */
`timescale 1ns / 1ps

module e2pd_queue
    import e2pd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_next   = push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next   = pop ? rd_reg + QPTR_W'(1) : rd_reg;
        fill_next = fill_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

/* src/e2pd_back.sv */
`timescale 1ns / 1ps

module e2pd_back
    import e2pd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  cmd_t q_head,
    output logic pop,
    output logic res_valid,
    output res_t res,
    input  logic res_ready
);

    typedef enum logic [4:0] {
        BK_IDLE  = 5'b00001,
        BK_RUN   = 5'b00010,
        BK_CRD   = 5'b00100,
        BK_CWR   = 5'b01000,
        BK_FLUSH = 5'b10000
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic [POS_W-1:0]  wp_reg, wp_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        rep_reg, rep_next;
    logic [5:0]        len_reg, len_next;
    logic [ADDR_W-1:0] dist_reg, dist_next;
    logic              fin_reg, fin_next;
    logic              err_reg, err_next;
    logic [31:0]       lanes_reg, lanes_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              ovalid_reg, ovalid_next;
    res_t              ores_reg, ores_next;

    logic [7:0]        hist_mem [PAGE_BYTES];
    logic [7:0]        rd_reg;
    logic              mem_re;
    logic              produce;
    logic              more;
    logic              stall;
    logic [7:0]        wbyte;
    logic              out_busy;

    assign out_busy  = ovalid_reg && !res_ready;
    assign res_valid = ovalid_reg;
    assign res       = ores_reg;

    // sequencer: pop an entry, run bytes, then back copy, then flush the partial word or the final result
    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        byte_next   = byte_reg;
        rep_next    = rep_reg;
        len_next    = len_reg;
        dist_next   = dist_reg;
        fin_next    = fin_reg;
        err_next    = err_reg;
        lanes_next  = lanes_reg;
        cnt_next    = cnt_reg;
        ovalid_next = res_ready ? 1'b0 : ovalid_reg;
        ores_next   = ores_reg;
        pop         = 1'b0;
        mem_re      = 1'b0;
        produce     = 1'b0;
        more        = 1'b0;
        wbyte       = byte_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    byte_next  = q_head.byte_val;
                    rep_next   = q_head.rep;
                    len_next   = q_head.copy_len;
                    dist_next  = q_head.offs;
                    fin_next   = q_head.final_step;
                    err_next   = q_head.err;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (rep_reg != 8'd0)
                begin
                    more    = (rep_reg != 8'd1) || (len_reg != 6'd0);
                    produce = 1'b1;
                end
                else if (len_reg != 6'd0)
                begin
                    state_next = BK_CRD;
                end
                else
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_CRD:
            begin
                mem_re     = 1'b1;
                state_next = BK_CWR;
            end
            BK_CWR:
            begin
                more    = (len_reg != 6'd1);
                wbyte   = rd_reg;
                produce = 1'b1;
            end
            BK_FLUSH:
            begin
                if (cnt_reg != 3'd0 || fin_reg)
                begin
                    if (!out_busy)
                    begin
                        ovalid_next      = 1'b1;
                        ores_next.data   = lanes_reg;
                        ores_next.count  = cnt_reg;
                        ores_next.last   = fin_reg;
                        ores_next.status = err_reg;
                        ores_next.total  = wp_reg;
                        lanes_next       = '0;
                        cnt_next         = '0;
                        if (fin_reg)
                        begin
                            wp_next = '0;
                        end
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // a full word mid-step goes straight to the output register; hold while the previous result is not yet taken
        stall = produce && (cnt_reg == 3'd3) && more && out_busy;
        if (produce && !stall)
        begin
            wp_next = wp_reg + POS_W'(1);
            if (state_reg == BK_RUN)
            begin
                rep_next = rep_reg - 8'd1;
            end
            else
            begin
                len_next   = len_reg - 6'd1;
                state_next = more ? BK_CRD : BK_FLUSH;
            end
            unique case (cnt_reg[1:0])
                2'd0: lanes_next = {lanes_reg[31:8], wbyte};
                2'd1: lanes_next = {lanes_reg[31:16], wbyte, lanes_reg[7:0]};
                2'd2: lanes_next = {lanes_reg[31:24], wbyte, lanes_reg[15:0]};
                2'd3: lanes_next = {wbyte, lanes_reg[23:0]};
                default: lanes_next = lanes_reg;
            endcase
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd3 && more)
            begin
                ovalid_next      = 1'b1;
                ores_next.data   = {wbyte, lanes_reg[23:0]};
                ores_next.count  = 3'd4;
                ores_next.last   = 1'b0;
                ores_next.status = 1'b0;
                ores_next.total  = wp_reg + POS_W'(1);
                lanes_next       = '0;
                cnt_next         = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            wp_reg     <= '0;
            rep_reg    <= '0;
            len_reg    <= '0;
            fin_reg    <= 1'b0;
            err_reg    <= 1'b0;
            lanes_reg  <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rep_reg    <= rep_next;
            len_reg    <= len_next;
            fin_reg    <= fin_next;
            err_reg    <= err_next;
            lanes_reg  <= lanes_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        dist_reg <= dist_next;
        ores_reg <= ores_next;
    end

    // page history store
    always_ff @(posedge clk)
    begin
        if (produce && !stall)
        begin
            hist_mem[wp_reg[ADDR_W-1:0]] <= wbyte;
        end
        if (mem_re)
        begin
            rd_reg <= hist_mem[wp_reg[ADDR_W-1:0] - dist_reg];
        end
    end

endmodule

/* src/exepack2_page_decompressor.sv */
`timescale 1ns / 1ps
// an item passes the transaction queue, the back-end sequencer and the output register on its way out
// run and literal bytes are written from the run state, each back-copied byte by a read state and a
// write state; each item also takes a queue pop, a record end and a flush step, and the next entry
// is popped only after that flush; the single-port history read sets the copy rate
// input is taken whenever the four-entry transaction queue has room
// reset: asynchronous, active low; clears decoder, queue and output, history is not cleared

module exepack2_page_decompressor
    import e2pd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // src_byte
    input  logic        s_tlast,   // src_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_bytes[31:0], byte_count[34:32], total_length[47:35]
    output logic        m_tlast,   // is_last
    output logic        m_tuser    // status
);

    logic accept;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    cmd_t push_cmd;
    cmd_t q_head;
    res_t res;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    e2pd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .src_byte (s_tdata),
        .src_last (s_tlast),
        .push     (push),
        .cmd      (push_cmd)
    );

    e2pd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    e2pd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    // result packing
    assign m_tdata = {res.total, res.count, res.data};
    assign m_tlast = res.last;
    assign m_tuser = res.status;

`ifndef SYNTHESIS
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("malformed status on a non-final result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[34:32] <= 3'd4)
        else $error("byte count above four");

    a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast && m_tdata[34:32] != 3'd4 |-> m_tdata[34:32] != 3'd0)
        else $error("empty non-final result");
`endif

endmodule

/* bench/exepack2_page_decompressor_tb.sv */
`timescale 1ns / 1ps

module exepack2_page_decompressor_tb;
    import e2pd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 130;

    // verdicts of one decoded byte
    localparam int DEC_GO  = 0;
    localparam int DEC_END = 1;
    localparam int DEC_BAD = 2;

    typedef enum int {
        PH_HDR,
        PH_HDR_MORE,
        PH_RUN_CNT,
        PH_RUN_VAL,
        PH_LIT,
        PH_SKIP
    } phase_e;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // page decoder mirror
    bit [7:0] hist [PAGE_BYTES];
    int       wr_pos;
    int       hdr_word;
    int       hdr_cnt;
    int       lits_left;
    int       copy_len;
    int       copy_dist;
    phase_e   phase;
    bit [7:0] step_bytes [$];
    res_t     expected_q [$];

    int errors;
    int items_sent;
    int idle_cycles;
    int burst_left;

    exepack2_page_decompressor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // decoder mirror helpers
    function automatic void emit_byte(bit [7:0] v);
        if (wr_pos < PAGE_BYTES)
        begin
            hist[wr_pos] = v;
            wr_pos++;
        end
        step_bytes.push_back(v);
    endfunction

    function automatic void back_copy(int len, int offs);
        for (int j = 0; j < len; j++)
        begin
            if (offs == 0 || offs > wr_pos || wr_pos >= PAGE_BYTES)
                return;
            emit_byte(hist[wr_pos - offs]);
        end
    endfunction

    function automatic void lits_then_copy(int lit, int len, int offs);
        if (lit > 0)
        begin
            lits_left = lit;
            copy_len  = len;
            copy_dist = offs;
            phase     = PH_LIT;
        end
        else
        begin
            back_copy(len, offs);
            phase = PH_HDR;
        end
    endfunction

    function automatic void clear_record();
        hdr_word  = 0;
        hdr_cnt   = 0;
        lits_left = 0;
        copy_len  = 0;
        copy_dist = 0;
    endfunction

    function automatic int decode_byte(bit [7:0] b, bit last);
        int w;
        int lit;
        int len;
        int offs;
        int need;
        case (phase)
            PH_HDR:
            begin
                if (b[1:0] == KIND_RUN_OR_LIT)
                begin
                    if (b == 8'd0)
                    begin
                        if (last)
                            return DEC_END;
                        phase = PH_RUN_CNT;
                        return DEC_GO;
                    end
                    len = int'(b >> 2);
                    if (wr_pos + len > PAGE_BYTES)
                        return DEC_BAD;
                    lits_left = len;
                    copy_len  = 0;
                    copy_dist = 0;
                    phase     = PH_LIT;
                    return DEC_GO;
                end
                hdr_word = int'(b);
                hdr_cnt  = 1;
                phase    = PH_HDR_MORE;
                return DEC_GO;
            end
            PH_HDR_MORE:
            begin
                hdr_word |= int'(b) << (8 * (hdr_cnt & 3));
                hdr_cnt++;
                need = (hdr_word[1:0] == KIND_LONG) ? 3 : 2;
                if (hdr_cnt < need)
                    return DEC_GO;
                hdr_cnt = 0;
                w = hdr_word;
                if (w[1:0] == KIND_SHORT)
                begin
                    w &= 'hFFFF;
                    lit  = (w >> 2) & 3;
                    len  = ((w >> 4) & 7) + 3;
                    offs = w >> 7;
                    if (wr_pos + lit + len > PAGE_BYTES)
                        return DEC_BAD;
                    if (offs == 0 || offs > wr_pos + lit)
                        return DEC_BAD;
                    lits_then_copy(lit, len, offs);
                end
                else if (w[1:0] == KIND_COPY)
                begin
                    w &= 'hFFFF;
                    len  = ((w >> 2) & 3) + 3;
                    offs = w >> 4;
                    if (offs == 0 || offs > wr_pos || wr_pos + len > PAGE_BYTES)
                        return DEC_BAD;
                    lits_then_copy(0, len, offs);
                end
                else
                begin
                    w &= 'hFFFFFF;
                    lit  = (w >> 2) & 'hF;
                    len  = (w >> 6) & 'h3F;
                    offs = w >> 12;
                    if (wr_pos + lit + len > PAGE_BYTES)
                        return DEC_BAD;
                    if (len > 0 && (offs == 0 || offs > wr_pos + lit))
                        return DEC_BAD;
                    lits_then_copy(lit, len, offs);
                end
                return DEC_GO;
            end
            PH_RUN_CNT:
            begin
                if (b == 8'd0)
                    return DEC_END;
                hdr_word = int'(b);
                phase    = PH_RUN_VAL;
                return DEC_GO;
            end
            PH_RUN_VAL:
            begin
                if (wr_pos + hdr_word > PAGE_BYTES)
                    return DEC_BAD;
                for (int k = 0; k < (hdr_word & 'hFF); k++)
                    emit_byte(b);
                hdr_word = 0;
                phase    = PH_HDR;
                return DEC_GO;
            end
            PH_LIT:
            begin
                emit_byte(b);
                if (lits_left > 0)
                    lits_left--;
                if (lits_left == 0)
                begin
                    back_copy(copy_len, copy_dist);
                    copy_len  = 0;
                    copy_dist = 0;
                    phase     = PH_HDR;
                end
                return DEC_GO;
            end
            default:
            begin
                phase = PH_HDR;
                return DEC_BAD;
            end
        endcase
    endfunction

    // expected results for one accepted compressed byte
    function automatic void predict_page_bytes(bit [7:0] b, bit last);
        int   start;
        int   verdict;
        int   nres;
        int   cnt;
        int   running;
        res_t r;
        step_bytes.delete();
        if (phase == PH_SKIP)
        begin
            if (last)
            begin
                wr_pos = 0;
                clear_record();
                phase = PH_HDR;
            end
            return;
        end
        start   = wr_pos;
        verdict = decode_byte(b, last);
        if (verdict == DEC_GO && last)
            verdict = (phase == PH_HDR) ? DEC_END : DEC_BAD;
        nres = (step_bytes.size() + 3) / 4;
        if (verdict != DEC_GO && nres == 0)
            nres = 1;
        running = start;
        for (int i = 0; i < nres; i++)
        begin
            cnt = step_bytes.size() - i * 4;
            if (cnt > 4)
                cnt = 4;
            r = '0;
            for (int k = 0; k < cnt; k++)
                r.data[8*k +: 8] = step_bytes[i*4 + k];
            running += cnt;
            r.count  = 3'(cnt);
            r.last   = (verdict != DEC_GO && i + 1 == nres);
            r.status = (verdict == DEC_BAD && i + 1 == nres);
            r.total  = POS_W'(running);
            expected_q.push_back(r);
        end
        if (verdict != DEC_GO)
        begin
            clear_record();
            if (last)
            begin
                wr_pos = 0;
                phase  = PH_HDR;
            end
            else
                phase = PH_SKIP;
        end
    endfunction

    // one byte transaction on the input side, in bursts with gaps
    task automatic send_byte(bit [7:0] b, bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_page_bytes(b, last);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_list(bit [7:0] bytes [$], bit last_on_end);
        foreach (bytes[i])
            send_byte(bytes[i], last_on_end && i == bytes.size() - 1);
    endtask

    task automatic test_runs_and_literals();
        bit [7:0] lits [$];
        send_list('{8'h00, 8'h05, 8'hAA, 8'h00, 8'hFF, 8'h55, 8'h04, 8'hFF}, 1'b0);
        lits.push_back(8'hFC);
        for (int i = 0; i < 63; i++)
            lits.push_back(8'($urandom_range(0, 255)));
        send_list(lits, 1'b0);
        // zero count ends the page, the trailing byte is dropped
        send_list('{8'h00, 8'h00, 8'h12}, 1'b1);
    endtask

    task automatic test_copy_forms();
        // four literals, short form with overlap, copy form, long forms
        send_list('{8'h10, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b0);
        send_list('{8'h85, 8'h00, 8'h77}, 1'b0);
        send_list('{8'h5E, 8'h00}, 1'b0);
        send_list('{8'h03, 8'h00, 8'hF0}, 1'b0);
        send_list('{8'hCB, 8'h2F, 8'h00, 8'h09, 8'h08}, 1'b0);
        // zero header with the last flag ends the page
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_page_ends();
        // last flag on a completing byte, then on truncated records
        send_list('{8'h00, 8'h03, 8'h41}, 1'b1);
        send_list('{8'h00, 8'h04}, 1'b1);
        send_byte(8'h01, 1'b1);
        send_list('{8'h08, 8'h61, 8'h62, 8'hC7}, 1'b1);
    endtask

    task automatic test_bad_distance();
        // distance zero, then one past the written bytes
        send_list('{8'h08, 8'hA1, 8'hA2, 8'h02, 8'h00, 8'h11, 8'h22}, 1'b1);
        send_list('{8'h08, 8'hB1, 8'hB2, 8'h32, 8'h00, 8'h33}, 1'b1);
        // short form reaching exactly its own literal
        send_list('{8'h85, 8'h00, 8'h5A}, 1'b1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < 17; i++)
            send_list('{8'h00, 8'hFF, 8'(i)}, 1'b0);
        send_byte(8'hEE, 1'b1);
    endtask

    // one page of mostly well-formed records with random content
    task automatic send_random_page();
        bit [7:0] rec [$];
        int nrec;
        int kind;
        int wp;
        int lit;
        int len;
        int offs;
        int w;
        int ending;
        wp   = 0;
        nrec = $urandom_range(1, 10);
        ending = $urandom_range(0, 9);
        for (int n = 0; n < nrec; n++)
        begin
            rec.delete();
            kind = $urandom_range(0, 5);
            if (kind == 5)
                rec.push_back(8'($urandom_range(0, 255)));
            else if (kind == 0 || (kind == 3 && wp == 0))
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 16);
                rec = '{8'h00, 8'(len), 8'($urandom_range(0, 255))};
                wp += len;
            end
            else if (kind == 1)
            begin
                lit = $urandom_range(1, 63);
                rec.push_back(8'(lit << 2));
                for (int i = 0; i < lit; i++)
                    rec.push_back(8'($urandom_range(0, 255)));
                wp += lit;
            end
            else if (kind == 2)
            begin
                lit  = $urandom_range(0, 3);
                len  = $urandom_range(3, 10);
                offs = $urandom_range(1, (wp + lit > 0) ? ((wp + lit > 511) ? 511 : wp + lit) : 1);
                if ($urandom_range(0, 15) == 0)
                    offs = $urandom_range(0, 1) ? 0 : ((wp + lit + 1) & 511);
                w = 1 | (lit << 2) | ((len - 3) << 4) | (offs << 7);
                rec = '{8'(w), 8'(w >> 8)};
                for (int i = 0; i < lit; i++)
                    rec.push_back(8'($urandom_range(0, 255)));
                wp += lit + len;
            end
            else if (kind == 3)
            begin
                len  = $urandom_range(3, 6);
                offs = $urandom_range(1, (wp > 4095) ? 4095 : wp);
                if ($urandom_range(0, 15) == 0)
                    offs = $urandom_range(0, 1) ? 0 : ((wp + 1) & 4095);
                w = 2 | ((len - 3) << 2) | (offs << 4);
                rec = '{8'(w), 8'(w >> 8)};
                wp += len;
            end
            else
            begin
                lit  = $urandom_range(0, 15);
                len  = $urandom_range(0, 63);
                if (wp + lit == 0)
                    len = 0;
                offs = (len == 0) ? $urandom_range(0, 4095)
                     : $urandom_range(1, (wp + lit > 4095) ? 4095 : wp + lit);
                if (len > 0 && $urandom_range(0, 15) == 0)
                    offs = $urandom_range(0, 1) ? 0 : ((wp + lit + 1) & 4095);
                w = 3 | (lit << 2) | (len << 6) | (offs << 12);
                rec = '{8'(w), 8'(w >> 8), 8'(w >> 16)};
                for (int i = 0; i < lit; i++)
                    rec.push_back(8'($urandom_range(0, 255)));
                wp += lit + len;
            end
            // truncate the closing record now and then
            if (n == nrec - 1 && ending == 0 && rec.size() > 1)
            begin
                rec = rec[0:$urandom_range(0, rec.size() - 2)];
                send_list(rec, 1'b1);
                return;
            end
            send_list(rec, n == nrec - 1 && ending <= 3);
        end
        if (ending <= 3)
            return;
        if (ending <= 5)
        begin
            send_byte(8'h00, 1'b1);
            return;
        end
        send_list('{8'h00, 8'h00}, 1'b0);
        repeat ($urandom_range(0, 3))
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_random();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
            send_random_page();
    endtask

    // receiver stall pattern: spans of free running, random or mostly stalled, in random order
    initial
    begin
        int mode;
        int span;
        m_tready = 1'b0;
        mode = 0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(64, 256);
            end
            span--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction data=%h", m_tdata);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[31:0] !== e.data)
                begin
                    $error("out_bytes expected %h actual %h", e.data, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[34:32] !== e.count)
                begin
                    $error("byte_count expected %0d actual %0d", e.count, m_tdata[34:32]);
                    errors++;
                end
                if (m_tdata[47:35] !== e.total)
                begin
                    $error("total_length expected %0d actual %0d", e.total, m_tdata[47:35]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("is_last expected %0d actual %0d", e.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("exepack2_page_decompressor_tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        errors      = 0;
        items_sent  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        wr_pos      = 0;
        clear_record();
        phase = PH_HDR;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_runs_and_literals();
        test_copy_forms();
        test_page_ends();
        test_bad_distance();
        test_overflow();
        test_random();
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("exepack2_page_decompressor_tb passed");
        else
            $display("exepack2_page_decompressor_tb failed");
        $finish;
    end

endmodule
